/* rtl/sgd_pkg.sv */
// sgd_pkg: shared types, constants and helpers for the scanline gradient dither block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none
package sgd_pkg;

	localparam int LINES_DEF  = 192;
	localparam int FRAC_DEF   = 8;
	localparam int NUM_CH     = 3;
	localparam int CH_W       = 5;
	localparam int CH_MAX     = 31;
	localparam int REG_W      = 13;
	localparam int LINE_W     = 9;
	localparam int COLOR_W    = 15;
	localparam int TARGET_W   = 8;
	localparam int IDX_W      = 3;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 24;

	typedef enum logic [IDX_W-1:0] {
		REG_START_RED   = 3'd0,
		REG_START_GREEN = 3'd1,
		REG_START_BLUE  = 3'd2,
		REG_END_RED     = 3'd3,
		REG_END_GREEN   = 3'd4,
		REG_END_BLUE    = 3'd5,
		REG_GRADIENT_ON = 3'd6,
		REG_DITHER_ON   = 3'd7
	} sgd_reg_t;

	// stage load enables, one per lane pipeline stage
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} sgd_ld_t;

	typedef struct packed {
		logic gradient_on;
		logic dither_on;
	} sgd_mode_t;

	function automatic logic [COLOR_W-1:0] pack_rgb(input logic [NUM_CH-1:0][CH_W-1:0] ch);
		pack_rgb = ch;
	endfunction

endpackage
`default_nettype wire

/* rtl/scanline_gradient_dither.sv */
// scanline_gradient_dither: top level, config registers, target line stage, lanes, merge.
// Each word passes registered stages s1 to s6, then the output register in sgd_merge.
// Throughput: one word per cycle; each stage stalls only when the one after it is full.
// Reset (arst_n low, async): pipeline empty, carries/last target/last color zero,
// colors zero, gradient on, dither off. Depends on sgd_pkg, sgd_lane, sgd_merge.
`timescale 1ns / 1ps
`default_nettype none
module scanline_gradient_dither #(
	parameter int LINES     = sgd_pkg::LINES_DEF,
	parameter int FRAC_BITS = sgd_pkg::FRAC_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [sgd_pkg::IDX_W-1:0]       wr_index,
	input  wire logic [sgd_pkg::REG_W-1:0]       wr_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [sgd_pkg::S_TDATA_W-1:0]   s_tdata,  // [8:0] current_line
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [sgd_pkg::M_TDATA_W-1:0]   m_tdata   // [14:0] backdrop_color, [22:15] target_line
);
	localparam int SW = $clog2(LINES);
	localparam int LW = sgd_pkg::LINE_W + 2;

	logic [sgd_pkg::NUM_CH-1:0][sgd_pkg::REG_W-1:0] start_q, end_q;
	sgd_pkg::sgd_mode_t                             mode_q;

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic          rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
	logic [SW-1:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	logic [LW-1:0] t_inc;
	sgd_pkg::sgd_ld_t ld;

	logic [sgd_pkg::NUM_CH-1:0][sgd_pkg::REG_W-1:0] lane_v;
	logic [sgd_pkg::NUM_CH-1:0][sgd_pkg::CH_W-1:0]  lane_flat;
	logic [sgd_pkg::COLOR_W-1:0]                    color;
	logic [sgd_pkg::TARGET_W-1:0]                   target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			mode_q  <= '{gradient_on: 1'b1, dither_on: 1'b0};
		end else if (wr_en) begin
			unique case (sgd_pkg::sgd_reg_t'(wr_index))
				sgd_pkg::REG_START_RED:   start_q[0] <= wr_data;
				sgd_pkg::REG_START_GREEN: start_q[1] <= wr_data;
				sgd_pkg::REG_START_BLUE:  start_q[2] <= wr_data;
				sgd_pkg::REG_END_RED:     end_q[0] <= wr_data;
				sgd_pkg::REG_END_GREEN:   end_q[1] <= wr_data;
				sgd_pkg::REG_END_BLUE:    end_q[2] <= wr_data;
				sgd_pkg::REG_GRADIENT_ON: mode_q.gradient_on <= wr_data[0];
				sgd_pkg::REG_DITHER_ON:   mode_q.dither_on <= wr_data[0];
			endcase
		end
	end

	assign rdy6     = !v_s6 || rdy_o;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign ld       = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5, s6: rdy6};

	// next line; wrapped to zero at LINES when stored in t_s1
	assign t_inc = LW'(s_tdata[sgd_pkg::LINE_W-1:0]) + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) t_s1 <= (t_inc >= LW'(LINES)) ? '0 : SW'(t_inc);
		if (rdy2) t_s2 <= t_s1;
		if (rdy3) t_s3 <= t_s2;
		if (rdy4) t_s4 <= t_s3;
		if (rdy5) t_s5 <= t_s4;
		if (rdy6) t_s6 <= t_s5;
	end

	for (genvar c = 0; c < sgd_pkg::NUM_CH; c++) begin : g_lane
		sgd_lane #(
			.LINES     (LINES),
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk       (clk),
			.ld        (ld),
			.t_s1      (t_s1),
			.start_val (start_q[c]),
			.end_val   (end_q[c]),
			.v_s6      (lane_v[c]),
			.flat      (lane_flat[c])
		);
	end

	sgd_merge #(
		.LINES     (LINES),
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode_q),
		.valid_s6    (v_s6),
		.t_s6        (t_s6),
		.lane_v      (lane_v),
		.lane_flat   (lane_flat),
		.out_ready   (m_tready),
		.out_valid_q (m_tvalid),
		.color_q     (color),
		.target_q    (target),
		.rdy         (rdy_o)
	);

	assign m_tdata = {1'b0, target, color};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word did not enter stage 1");

	a_accept_while_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && !v_s1) |-> s_tready)
		else $error("input blocked although stage 1 is empty");

	a_stage6_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !rdy6) |=> (v_s6 && $stable(t_s6)))
		else $error("stalled stage 6 word changed");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> ((SW + 1)'(t_s6) < (SW + 1)'(LINES)))
		else $error("target line out of range");

endmodule
`default_nettype wire

/* rtl/sgd_lane.sv */
// sgd_lane: one color channel, line interpolation by reciprocal multiply plus flat average.
// Depends on sgd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgd_lane #(
	parameter int LINES     = sgd_pkg::LINES_DEF,
	parameter int FRAC_BITS = sgd_pkg::FRAC_DEF,
	localparam int SW       = $clog2(LINES)
) (
	input  wire logic                         clk,
	input  wire sgd_pkg::sgd_ld_t             ld,
	input  wire logic [SW-1:0]                t_s1,
	input  wire logic [sgd_pkg::REG_W-1:0]    start_val,
	input  wire logic [sgd_pkg::REG_W-1:0]    end_val,
	output logic      [sgd_pkg::REG_W-1:0]    v_s6,
	output logic      [sgd_pkg::CH_W-1:0]     flat
);
	localparam int SPAN = LINES - 1;
	localparam int NW   = sgd_pkg::REG_W + SW;
	localparam int KSH  = NW;
	localparam int MW   = NW + 1;
	localparam int PW   = NW + MW;
	localparam longint unsigned MUL = (64'd1 << KSH) / SPAN;
	localparam int CW   = (FRAC_BITS + sgd_pkg::CH_W > NW) ? FRAC_BITS + sgd_pkg::CH_W : NW;
	localparam logic [CW-1:0] CLAMP = CW'(sgd_pkg::CH_MAX) << FRAC_BITS;
	localparam int AW   = ((FRAC_BITS + 1 > sgd_pkg::REG_W + 1) ?
		FRAC_BITS + 1 : sgd_pkg::REG_W + 1) + 1;

	logic [NW-1:0] pa_s2, pb_s2;
	logic [NW-1:0] n_s3;
	logic [NW-1:0] n_s4, qe_s4;
	logic [NW-1:0] n_s5, qe_s5, qn_s5;
	logic [PW-1:0] prod;
	logic [NW-1:0] q_fix;
	logic [CW-1:0] q_ext;
	logic [AW-1:0] avg_sum, avg_sh;

	// n * floor(2^K/span) >> K is at most one below n/span
	assign prod  = PW'(n_s3) * PW'(MW'(MUL));
	assign q_fix = (n_s5 >= qn_s5) ? qe_s5 + NW'(1) : qe_s5;
	assign q_ext = CW'(q_fix);

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			pa_s2 <= NW'(start_val) * NW'(SW'(SPAN) - t_s1);
			pb_s2 <= NW'(end_val) * NW'(t_s1);
		end
		if (ld.s3) begin
			n_s3 <= pa_s2 + pb_s2;
		end
		if (ld.s4) begin
			n_s4  <= n_s3;
			qe_s4 <= NW'(prod >> KSH);
		end
		if (ld.s5) begin
			n_s5  <= n_s4;
			qe_s5 <= qe_s4;
			qn_s5 <= NW'(((NW + 1)'(qe_s4) + (NW + 1)'(1)) * (NW + 1)'(SPAN));
		end
		if (ld.s6) begin
			v_s6 <= (q_ext > CLAMP) ? sgd_pkg::REG_W'(CLAMP) : sgd_pkg::REG_W'(q_fix);
		end
	end

	// flat mode: rounded average, saturated
	assign avg_sum = AW'(start_val) + AW'(end_val) + (AW'(1) << FRAC_BITS);
	assign avg_sh  = avg_sum >> (FRAC_BITS + 1);
	assign flat    = (avg_sh > AW'(sgd_pkg::CH_MAX)) ? sgd_pkg::CH_W'(sgd_pkg::CH_MAX) :
		sgd_pkg::CH_W'(avg_sh);

endmodule
`default_nettype wire

/* rtl/sgd_merge.sv */
// sgd_merge: combines the three lanes, runs the dither carries and holds the output word.
// Depends on sgd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgd_merge #(
	parameter int LINES     = sgd_pkg::LINES_DEF,
	parameter int FRAC_BITS = sgd_pkg::FRAC_DEF,
	localparam int SW       = $clog2(LINES)
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire sgd_pkg::sgd_mode_t                              mode,
	input  wire logic                                            valid_s6,
	input  wire logic [SW-1:0]                                   t_s6,
	input  wire logic [sgd_pkg::NUM_CH-1:0][sgd_pkg::REG_W-1:0]  lane_v,
	input  wire logic [sgd_pkg::NUM_CH-1:0][sgd_pkg::CH_W-1:0]   lane_flat,
	input  wire logic                                            out_ready,
	output logic                                                 out_valid_q,
	output logic      [sgd_pkg::COLOR_W-1:0]                     color_q,
	output logic      [sgd_pkg::TARGET_W-1:0]                    target_q,
	output logic                                                 rdy
);
	localparam int SPAN = LINES - 1;
	localparam int XW   = ((FRAC_BITS > sgd_pkg::REG_W) ? FRAC_BITS : sgd_pkg::REG_W) + 1;

	logic [sgd_pkg::NUM_CH-1:0][FRAC_BITS-1:0]     carry_q;
	logic [SW-1:0]                                 last_target_q;
	logic [sgd_pkg::COLOR_W-1:0]                   last_color_q;

	logic                                          t0, seq, last_line, carry_we, take;
	logic [sgd_pkg::NUM_CH-1:0][sgd_pkg::CH_W-1:0] d_ch, t_ch;
	logic [sgd_pkg::NUM_CH-1:0][FRAC_BITS-1:0]     d_carry;
	logic [sgd_pkg::COLOR_W-1:0]                   color_d;

	assign rdy  = !out_valid_q || out_ready;
	assign take = rdy && valid_s6;

	always_comb begin
		logic [FRAC_BITS-1:0] cin;
		logic [XW-1:0]        x;
		t0        = (t_s6 == '0);
		last_line = (t_s6 == SW'(SPAN));
		seq       = t0 || ((SW + 1)'(t_s6) == (SW + 1)'(last_target_q) + (SW + 1)'(1));
		for (int c = 0; c < sgd_pkg::NUM_CH; c++) begin
			cin        = t0 ? '0 : carry_q[c];
			x          = XW'(lane_v[c]) + XW'(cin);
			d_ch[c]    = sgd_pkg::CH_W'(x >> FRAC_BITS);
			d_carry[c] = last_line ? '0 : FRAC_BITS'(x);
			t_ch[c]    = sgd_pkg::CH_W'(lane_v[c] >> FRAC_BITS);
		end
		carry_we = mode.gradient_on && mode.dither_on && seq;
		priority if (!mode.gradient_on) begin
			color_d = sgd_pkg::pack_rgb(lane_flat);
		end else if (!mode.dither_on) begin
			color_d = sgd_pkg::pack_rgb(t_ch);
		end else if (seq) begin
			color_d = sgd_pkg::pack_rgb(d_ch);
		end else begin
			color_d = last_color_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			carry_q       <= '0;
			last_target_q <= '0;
			last_color_q  <= '0;
		end else begin
			if (rdy) begin
				out_valid_q <= valid_s6;
			end
			if (take) begin
				last_target_q <= t_s6;
				last_color_q  <= color_d;
				if (carry_we) begin
					carry_q <= d_carry;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			color_q  <= color_d;
			target_q <= sgd_pkg::TARGET_W'(t_s6);
		end
	end

endmodule
`default_nettype wire
